// ===== rtl/core/euler_to_quaternion_defines.svh =====
// Assertion macros for the euler_to_quaternion block
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH
`ifndef SYNTHESIS
// Check an implication in the next cycle, masked during reset
`define E2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Check an implication in the next cycle, also across reset
`define E2Q_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define E2Q_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define E2Q_ASSERT_NEXT_ALWAYS(label, clk, ante, cons)
`endif
`endif

// ===== rtl/core/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Constants and tables shared by the Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;
    localparam int unsigned ANGLE_W    = 16;
    localparam int unsigned QUAT_W     = 16;
    localparam int unsigned TRIG_W     = 32;
    localparam int unsigned CORDIC_W   = 34;
    localparam int unsigned CORDIC_N   = 20;
    // reduction, angle scale, CORDIC iterations, quadrant map
    localparam int unsigned SC_LAT     = CORDIC_N + 3;
    localparam int unsigned TURN_UNITS = 46080;
    localparam int unsigned QUAD_UNITS = 11520;
    localparam int unsigned RAD_Q30    = 146409;
    localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30  = 34'sd1073741824;

    typedef logic signed [TRIG_W-1:0]   t_trig;
    typedef logic signed [CORDIC_W-1:0] t_cordic;

    localparam t_cordic ATAN_Q30 [0:CORDIC_N-1] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048
    };
endpackage

// ===== rtl/core/e2q_if.sv =====
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channels for the angle input and the quaternion output.
// ----------------------------------------------------------------------------
interface e2q_angle_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// ===== rtl/core/e2q_half_sincos.sv =====
// ----------------------------------------------------------------------------
// e2q_half_sincos
// Pipelined cosine and sine of half an angle: turn reduction, quadrant
// split, one CORDIC iteration per stage, clamp and quadrant map.
// ----------------------------------------------------------------------------
module e2q_half_sincos (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]   i_angle,
    output e2q_pkg::t_trig                       o_cos,
    output e2q_pkg::t_trig                       o_sin
);
    import e2q_pkg::*;

    logic [15:0]  wrapped;
    logic [15:0]  turn;
    logic [1:0]   quad;
    logic [15:0]  quad_base;
    logic [13:0]  r_frac;
    logic [1:0]   r_quad;
    logic [31:0]  scaled;

    t_cordic    s_x [0:CORDIC_N];
    t_cordic    s_y [0:CORDIC_N];
    t_cordic    s_z [0:CORDIC_N];
    logic [1:0] s_q [0:CORDIC_N];

    t_cordic    cx;
    t_cordic    cy;
    t_trig      r_cos;
    t_trig      r_sin;

    // reduce the half angle to one turn and split off the quadrant
    always_comb begin
        wrapped = 16'(i_angle)
                  + (i_angle[ANGLE_W-1] ? 16'(TURN_UNITS) : 16'd0);
        turn    = wrapped;
        if (turn >= 16'(3 * QUAD_UNITS)) begin
            quad = 2'd3;
        end else if (turn >= 16'(2 * QUAD_UNITS)) begin
            quad = 2'd2;
        end else if (turn >= 16'(QUAD_UNITS)) begin
            quad = 2'd1;
        end else begin
            quad = 2'd0;
        end
        quad_base = 16'(quad) * 16'(QUAD_UNITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frac <= 14'(turn - quad_base);
            r_quad <= quad;
        end
    end

    // scale the remainder to radians in Q30 and seed the rotation
    assign scaled = 32'(r_frac) * 32'(RAD_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            s_x[0] <= GAIN_Q30;
            s_y[0] <= '0;
            s_z[0] <= t_cordic'({2'b00, scaled});
            s_q[0] <= r_quad;
        end
    end

    // rotate one iteration per stage
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
        t_cordic dx;
        t_cordic dy;
        assign dx = s_y[i] >>> i;
        assign dy = s_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!s_z[i][CORDIC_W-1]) begin
                    s_x[i+1] <= s_x[i] - dx;
                    s_y[i+1] <= s_y[i] + dy;
                    s_z[i+1] <= s_z[i] - ATAN_Q30[i];
                end else begin
                    s_x[i+1] <= s_x[i] + dx;
                    s_y[i+1] <= s_y[i] - dy;
                    s_z[i+1] <= s_z[i] + ATAN_Q30[i];
                end
                s_q[i+1] <= s_q[i];
            end
        end
    end

    // clamp to unit range
    always_comb begin
        cx = s_x[CORDIC_N];
        cy = s_y[CORDIC_N];
        if (cx > ONE_Q30) cx = ONE_Q30;
        if (cx < -ONE_Q30) cx = -ONE_Q30;
        if (cy > ONE_Q30) cy = ONE_Q30;
        if (cy < -ONE_Q30) cy = -ONE_Q30;
    end

    // map the first-quadrant pair to the full circle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (s_q[CORDIC_N])
                2'd0: begin
                    r_cos <= t_trig'(cx);
                    r_sin <= t_trig'(cy);
                end
                2'd1: begin
                    r_cos <= t_trig'(-cy);
                    r_sin <= t_trig'(cx);
                end
                2'd2: begin
                    r_cos <= t_trig'(-cx);
                    r_sin <= t_trig'(-cy);
                end
                default: begin
                    r_cos <= t_trig'(cy);
                    r_sin <= t_trig'(-cx);
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

// ===== rtl/core/euler_to_quaternion.sv =====
// Pipeline: input capture, reduction, angle scale, the 20-stage CORDIC
// pipeline, quadrant map, product and rounding stages.
// Throughput: one item per cycle; a stalled output freezes every stage.
// Reset: synchronous, active low, clears the stage valid bits only.
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles to a saturated fixed-point unit quaternion.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion #(
    parameter int unsigned QUAT_FRAC_BITS = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    e2q_angle_if.sink     i_angle,
    e2q_quat_if.source    o_quat
);
    import e2q_pkg::*;

    localparam int unsigned LAT = SC_LAT + 4;
    localparam int unsigned SH  = 60 - QUAT_FRAC_BITS;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (SH - 1);

    logic              en;
    logic [LAT-1:0]    r_vld;
    logic signed [15:0] r_roll;
    logic signed [15:0] r_pitch;
    logic signed [15:0] r_yaw;
    t_trig cr, sr, cp, sp, cy, sy;
    t_trig r_crcp, r_srsp, r_srcp, r_crsp;
    t_trig r_cy, r_sy;
    logic signed [63:0] r_t [0:7];
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;

    function automatic logic signed [15:0] finish(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = (v + HALF_LSB) >>> SH;
        if (s > 64'sd32767) return 16'sh7fff;
        if (s < -64'sd32768) return 16'sh8000;
        return s[15:0];
    endfunction

    function automatic t_trig mul_q30(input t_trig a, input t_trig b);
        logic signed [63:0] p;
        p = a * b;
        p = (p + 64'sd536870912) >>> 30;
        return p[TRIG_W-1:0];
    endfunction

    // advance all stages unless the output holds an untaken result
    assign en            = !r_vld[LAT-1] || o_quat.ready;
    assign i_angle.ready = en;

    // shift valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_angle.valid};
        end
    end

    // capture the input transfer
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll  <= i_angle.roll_angle;
            r_pitch <= i_angle.pitch_angle;
            r_yaw   <= i_angle.yaw_angle;
        end
    end

    e2q_half_sincos u_roll  (.i_clk, .i_en(en), .i_angle(r_roll),  .o_cos(cr), .o_sin(sr));
    e2q_half_sincos u_pitch (.i_clk, .i_en(en), .i_angle(r_pitch), .o_cos(cp), .o_sin(sp));
    e2q_half_sincos u_yaw   (.i_clk, .i_en(en), .i_angle(r_yaw),   .o_cos(cy), .o_sin(sy));

    // roll-pitch pair products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_crcp <= mul_q30(cr, cp);
            r_srsp <= mul_q30(sr, sp);
            r_srcp <= mul_q30(sr, cp);
            r_crsp <= mul_q30(cr, sp);
            r_cy   <= cy;
            r_sy   <= sy;
        end
    end

    // triple products with the yaw terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[0] <= r_srcp * r_cy;
            r_t[1] <= r_crsp * r_sy;
            r_t[2] <= r_crsp * r_cy;
            r_t[3] <= r_srcp * r_sy;
            r_t[4] <= r_crcp * r_sy;
            r_t[5] <= r_srsp * r_cy;
            r_t[6] <= r_crcp * r_cy;
            r_t[7] <= r_srsp * r_sy;
        end
    end

    // combine, round and saturate into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx <= finish(r_t[0] - r_t[1]);
            r_qy <= finish(r_t[2] + r_t[3]);
            r_qz <= finish(r_t[4] - r_t[5]);
            r_qw <= finish(r_t[6] + r_t[7]);
        end
    end

    assign o_quat.valid  = r_vld[LAT-1];
    assign o_quat.quat_x = r_qx;
    assign o_quat.quat_y = r_qy;
    assign o_quat.quat_z = r_qz;
    assign o_quat.quat_w = r_qw;

    `E2Q_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, r_vld == '0)
    `E2Q_ASSERT_NEXT(a_stall_freeze, i_clk, i_rst_n, !en, $stable(r_vld))
    `E2Q_ASSERT_NEXT(a_item_advance, i_clk, i_rst_n, en && r_vld[0], r_vld[1])
endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for euler_to_quaternion: drives angle triples over the
// input channel, predicts each quaternion with a bit-exact CORDIC model and
// compares every output transfer against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 15;
    localparam int LATENCY     = 27;
    localparam int WDOG_LIMIT  = 20000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    e2q_angle_if angle_ch();
    e2q_quat_if  quat_ch();

    euler_to_quaternion #(.QUAT_FRAC_BITS(FRAC_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_angle(angle_ch.sink),
        .o_quat (quat_ch.source)
    );

    always #5 i_clk = ~i_clk;

    t_quat quat_expected[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    src_idle_en = 1'b1;
    bit    snk_idle_en = 1'b1;
    bit    hold_output = 1'b0;

    localparam longint ATAN_TAB [0:19] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048
    };
    localparam longint Q30_ONE = 64'sd1073741824;

    // Floor division by a power of two; >>> on longint is arithmetic
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > Q30_ONE) return Q30_ONE;
        if (v < -Q30_ONE) return -Q30_ONE;
        return v;
    endfunction

    // Half-angle cosine and sine in Q30 via quadrant split and CORDIC
    function automatic void half_angle_trig(input logic signed [15:0] ang,
                                            output longint c_o, output longint s_o);
        longint r, f, x, y, z, dx, dy, c, s;
        int q;
        r = longint'(ang) % 46080;
        if (r < 0) r += 46080;
        q = int'(r / 11520);
        f = r % 11520;
        z = f * 146409;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 20; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TAB[i];
            end
        end
        c = clamp_unit(x);
        s = clamp_unit(y);
        case (q)
            0: begin c_o = c;  s_o = s;  end
            1: begin c_o = -s; s_o = c;  end
            2: begin c_o = -c; s_o = -s; end
            default: begin c_o = s; s_o = -c; end
        endcase
    endfunction

    function automatic longint pair_mul(longint a, longint b);
        return asr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic signed [15:0] round_sat(longint q60);
        int sh;
        longint v;
        sh = 60 - FRAC_BITS;
        v = asr(q60 + (64'sd1 <<< (sh - 1)), sh);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_quat predict_quat(logic signed [15:0] roll,
                                           logic signed [15:0] pitch,
                                           logic signed [15:0] yaw);
        longint cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
        t_quat q;
        half_angle_trig(roll, cr, sr);
        half_angle_trig(pitch, cp, sp);
        half_angle_trig(yaw, cy, sy);
        crcp = pair_mul(cr, cp);
        srsp = pair_mul(sr, sp);
        srcp = pair_mul(sr, cp);
        crsp = pair_mul(cr, sp);
        q.x = round_sat(srcp * cy - crsp * sy);
        q.y = round_sat(crsp * cy + srcp * sy);
        q.z = round_sat(crcp * sy - srsp * cy);
        q.w = round_sat(crcp * cy + srsp * sy);
        return q;
    endfunction

    // Offer one angle triple, hold until the transfer, predict on acceptance
    task automatic send_angles(logic signed [15:0] roll, logic signed [15:0] pitch,
                               logic signed [15:0] yaw);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            angle_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        angle_ch.valid       <= 1'b1;
        angle_ch.roll_angle  <= roll;
        angle_ch.pitch_angle <= pitch;
        angle_ch.yaw_angle   <= yaw;
        @(posedge i_clk);
        while (!angle_ch.ready) @(posedge i_clk);
        quat_expected.push_back(predict_quat(roll, pitch, yaw));
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return 16'(16'sh8000 + $urandom_range(0, 63));
            1: return 16'(16'sh7fff - $urandom_range(0, 63));
            2: return 16'($urandom_range(0, 255) - 128);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [15:0] vals [0:7];
        vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                 16'sd11520, -16'sd11520, 16'sd23040, 16'sh0001};
        for (int i = 0; i < 8; i++) send_angles(vals[i], vals[7 - i], vals[(i + 3) % 8]);
        // Quadrant boundaries of the half angle and wrap past one turn
        send_angles(16'sd5760, 16'sd5760, 16'sd5760);
        send_angles(-16'sd23040, 16'sd11519, 16'sd11521);
        send_angles(16'sd0, 16'sd23039, -16'sd23041);
        send_angles(16'sd1, 16'sd0, 16'sd0);
        send_angles(16'sd0, 16'sd1, 16'sd0);
        send_angles(16'sd0, 16'sd0, 16'sd1);
        send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
        send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    // Stall the output long enough to fill the pipeline and block the input
    task automatic test_backpressure();
        hold_output = 1'b1;
        fork
            begin
                repeat (120) @(posedge i_clk);
                hold_output = 1'b0;
            end
            test_random(80);
        join
    endtask

    task automatic test_full_rate();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random(300);
    endtask

    // Output sink: random bursts of idling, long hold on request
    initial begin
        int gap;
        quat_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_output) begin
                quat_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 8);
                quat_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                quat_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            if (quat_expected.size() == 0) begin
                $error("unexpected output x=%0d y=%0d z=%0d w=%0d", quat_ch.quat_x,
                       quat_ch.quat_y, quat_ch.quat_z, quat_ch.quat_w);
                errors++;
            end else begin
                exp_q = quat_expected.pop_front();
                if (quat_ch.quat_x !== exp_q.x) begin
                    $error("quat_x expected %0d actual %0d", exp_q.x, quat_ch.quat_x);
                    errors++;
                end
                if (quat_ch.quat_y !== exp_q.y) begin
                    $error("quat_y expected %0d actual %0d", exp_q.y, quat_ch.quat_y);
                    errors++;
                end
                if (quat_ch.quat_z !== exp_q.z) begin
                    $error("quat_z expected %0d actual %0d", exp_q.z, quat_ch.quat_z);
                    errors++;
                end
                if (quat_ch.quat_w !== exp_q.w) begin
                    $error("quat_w expected %0d actual %0d", exp_q.w, quat_ch.quat_w);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((angle_ch.valid && angle_ch.ready) || (quat_ch.valid && quat_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        angle_ch.valid       <= 1'b0;
        angle_ch.roll_angle  <= '0;
        angle_ch.pitch_angle <= '0;
        angle_ch.yaw_angle   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random(950);
        test_backpressure();
        test_full_rate();
        angle_ch.valid <= 1'b0;
        while (quat_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/e2q_pkg.sv
rtl/core/e2q_if.sv
rtl/core/e2q_half_sincos.sv
rtl/core/euler_to_quaternion.sv
tb/tb_top.sv
